@@ design/u8sd_pkg.sv @@
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants for the UTF-8 stream decoder: byte classes,
// the queue entry passed from the front to the back, and the result beat.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  // Look-ahead window and front queue sizes
  localparam int WIN_DEPTH   = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // Field widths of the result beat
  localparam int CP_BITS     = 21;
  localparam int LEN_BITS    = 3;
  localparam int OFS_BITS    = 32;

  // Substitute for any byte that does not start a valid sequence
  localparam logic [CP_BITS-1:0] REPL_CHAR = 21'h00FFFD;

  // Role of a byte when it stands at the front of the window
  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_BAD,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR
  } lead_t;

  // One stream byte with its precomputed class
  typedef struct packed {
    logic [7:0] data;
    logic       cont;
    lead_t      lead;
  } byte_info_t;

  // One entry of the front queue
  typedef struct packed {
    byte_info_t info;
    logic       eos;
  } q_entry_t;

  // One result beat
  typedef struct packed {
    logic [CP_BITS-1:0]  code_point;
    logic [LEN_BITS-1:0] seq_length;
    logic                replaced;
    logic [OFS_BITS-1:0] start_offset;
    logic                last_of_run;
  } res_t;

endpackage

@@ design/utf8_stream_decoder_top.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Lenient UTF-8 decoder with a four-byte look-ahead window.
//
// Input channel: drive data_byte and end_of_stream with push; a beat is
// taken at a clock edge where push is high and full is low. Set
// end_of_stream on the final byte of a stream to drain the window.
// Result channel: while empty is low, the oldest result sits on the result
// ports; pulse pop to take it. last_of_run marks the final result caused by
// one input byte.
// A byte that fills the window is written into the queue, then decoded from
// the queue head and registered in the result register. Throughput is one
// byte per cycle while pop keeps the result register free, set by the back
// end, which appends and decodes one window front per cycle. A flush beat
// drains the window at one result per cycle, during which the back end takes
// no new byte; a four-entry queue keeps the input side moving.
// Reset empties the window, the queue and the result register and clears the
// offset counter. When pop stays low the result register holds, the back end
// stops, the queue fills and full rises.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        empty,
  input  logic        pop,
  output logic [20:0] code_point,
  output logic [2:0]  seq_length,
  output logic        replaced,
  output logic [31:0] start_offset,
  output logic        last_of_run
);
  import u8sd_pkg::*;

  q_entry_t head;
  logic     head_valid;
  logic     take;
  logic     res_valid;
  res_t     res;

  // Accept and classify bytes
  u8sd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .head_valid    (head_valid),
    .head          (head),
    .take          (take)
  );

  // Decode the window and hold the result beat
  u8sd_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res),
    .res_pop    (pop)
  );

  // Split the result beat onto the ports
  assign empty        = !res_valid;
  assign code_point   = res.code_point;
  assign seq_length   = res.seq_length;
  assign replaced     = res.replaced;
  assign start_offset = res.start_offset;
  assign last_of_run  = res.last_of_run;

endmodule

@@ design/u8sd_front.sv @@
// ----------------------------------------------------------------------------
// u8sd_front
// Accepts stream bytes, classifies each one (continuation, lead length) and
// holds them in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module u8sd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte,
  input  logic               end_of_stream,
  output logic               head_valid,
  output u8sd_pkg::q_entry_t head,
  input  logic               take
);
  import u8sd_pkg::*;

  q_entry_t             entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 push_ok;
  logic                 take_ok;
  q_entry_t             new_entry;

  // Tag a raw byte with its role at the window front
  function automatic byte_info_t classify(input logic [7:0] b);
    byte_info_t r;
    r.data = b;
    r.cont = (b[7:6] == 2'b10);
    if (b <= 8'h7F) begin
      r.lead = LEAD_ASCII;
    end else if (b inside {[8'hC2:8'hDF]}) begin
      r.lead = LEAD_TWO;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      r.lead = LEAD_THREE;
    end else if (b inside {[8'hF0:8'hF4]}) begin
      r.lead = LEAD_FOUR;
    end else begin
      r.lead = LEAD_BAD;
    end
    return r;
  endfunction

  assign full       = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign push_ok    = push && !full;
  assign take_ok    = take && head_valid;

  always_comb begin
    new_entry.info = classify(data_byte);
    new_entry.eos  = end_of_stream;
  end

  // Store the classified beat
  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[wr_ptr] <= new_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_ok && !take_ok) begin
        count <= count + 1'b1;
      end else if (take_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/u8sd_back.sv @@
// ----------------------------------------------------------------------------
// u8sd_back
// Holds the four-byte look-ahead window, decodes its front once it is full
// or while an end-of-stream flush drains it, and registers each result beat.
// ----------------------------------------------------------------------------
module u8sd_back #(
  parameter int OFFSET_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  u8sd_pkg::q_entry_t head,
  output logic               take,
  output logic               res_valid,
  output u8sd_pkg::res_t     res,
  input  logic               res_pop
);
  import u8sd_pkg::*;

  byte_info_t              win [WIN_DEPTH];
  logic [2:0]              fill;
  logic                    flushing;
  logic [OFFSET_BITS-1:0]  offset;

  byte_info_t              app_win [WIN_DEPTH];
  logic [2:0]              app_fill;
  byte_info_t              shift_win [WIN_DEPTH];
  logic [2:0]              rem_fill;
  logic                    c1, c2, c3;
  logic [CP_BITS-1:0]      cp;
  logic [LEN_BITS-1:0]     len;
  logic                    repl;
  logic                    emit;
  logic                    out_space;
  logic                    step;
  logic                    eos_mode;
  logic [OFS_BITS-1:0]     offset_low;
  res_t                    res_next;

  // Offset field carries the low bits of the running offset, zero-extended when the counter is narrower
  if (OFFSET_BITS >= OFS_BITS) begin : g_ofs_trunc
    assign offset_low = offset[OFS_BITS-1:0];
  end else begin : g_ofs_ext
    assign offset_low = {{(OFS_BITS-OFFSET_BITS){1'b0}}, offset};
  end

  // Append the head byte unless draining a flush
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (!flushing && (fill[1:0] == 2'(i))) begin
        app_win[i] = head.info;
      end else begin
        app_win[i] = win[i];
      end
    end
    app_fill = flushing ? fill : fill + 3'd1;
  end

  // Decode the window front
  always_comb begin
    c1 = app_win[1].cont && (app_fill > 3'd1);
    c2 = app_win[2].cont && (app_fill > 3'd2);
    c3 = app_win[3].cont && (app_fill > 3'd3);
    cp   = REPL_CHAR;
    len  = 3'd1;
    repl = 1'b1;
    case (app_win[0].lead)
      LEAD_ASCII: begin
        cp   = {13'd0, app_win[0].data};
        repl = 1'b0;
      end
      LEAD_TWO: begin
        if (c1) begin
          cp   = {10'd0, app_win[0].data[4:0], app_win[1].data[5:0]};
          len  = 3'd2;
          repl = 1'b0;
        end
      end
      LEAD_THREE: begin
        if (c1 && c2) begin
          cp   = {5'd0, app_win[0].data[3:0], app_win[1].data[5:0],
                  app_win[2].data[5:0]};
          len  = 3'd3;
          repl = 1'b0;
        end
      end
      LEAD_FOUR: begin
        if (c1 && c2 && c3) begin
          cp   = {app_win[0].data[2:0], app_win[1].data[5:0],
                  app_win[2].data[5:0], app_win[3].data[5:0]};
          len  = 3'd4;
          repl = 1'b0;
        end
      end
      default: begin
        cp   = REPL_CHAR;
        len  = 3'd1;
        repl = 1'b1;
      end
    endcase
  end

  // Drop the consumed bytes from the window
  always_comb begin
    logic [2:0] src;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      src = 3'(i) + len;
      if (src < 3'(WIN_DEPTH)) begin
        shift_win[i] = app_win[src[1:0]];
      end else begin
        shift_win[i] = '0;
      end
    end
    rem_fill = app_fill - len;
  end

  // Decide whether this cycle advances
  assign eos_mode  = flushing || head.eos;
  assign emit      = flushing || (head_valid && ((app_fill == 3'(WIN_DEPTH)) || head.eos));
  assign out_space = !res_valid || res_pop;
  assign step      = flushing ? out_space : (head_valid && (!emit || out_space));
  assign take      = !flushing && step;

  always_comb begin
    res_next.code_point   = cp;
    res_next.seq_length   = len;
    res_next.replaced     = repl;
    res_next.start_offset = offset_low;
    res_next.last_of_run  = !eos_mode || (rem_fill == 3'd0);
  end

  // Window contents
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win[i] <= emit ? shift_win[i] : app_win[i];
      end
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (step && emit) begin
      res <= res_next;
    end
  end

  // Window control, offset and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      flushing  <= 1'b0;
      offset    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (step && emit) begin
        fill      <= rem_fill;
        flushing  <= eos_mode && (rem_fill != 3'd0);
        offset    <= offset + OFFSET_BITS'(len);
        res_valid <= 1'b1;
      end else begin
        if (step) begin
          fill <= app_fill;
        end
        if (res_pop) begin
          res_valid <= 1'b0;
        end
      end
    end
  end

endmodule

@@ dv/utf8_stream_decoder_chk.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_chk
// Watches both queue ports of the UTF-8 stream decoder. Keeps its own copy
// of the look-ahead window, predicts the code points that every accepted
// byte beat releases, and compares each popped result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_decoder_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  input  logic        empty,
  input  logic        pop,
  input  logic [20:0] code_point,
  input  logic [2:0]  seq_length,
  input  logic        replaced,
  input  logic [31:0] start_offset,
  input  logic        last_of_run,
  output int          fail_count,
  output int          pending
);
  import u8sd_pkg::*;

  // Predicted results, oldest first
  res_t                cp_expected[$];

  // Model copy of the decoder window
  logic [7:0]          win_bytes [WIN_DEPTH];
  logic [2:0]          win_fill;
  logic [OFS_BITS-1:0] win_offset;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Count a mismatch and print one line for it
  task automatic report(input string what);
    fail_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic logic is_cont(input int idx);
    return (idx < int'(win_fill)) && (win_bytes[idx][7:6] == 2'b10);
  endfunction

  // Decode the window front with the lenient rules
  function automatic void decode_front(output logic [20:0] cp, output logic [2:0] len,
                                       output logic repl);
    logic [7:0] b0;
    logic [5:0] b1;
    logic [5:0] b2;
    logic [5:0] b3;
    logic       bad_lead;
    b0 = win_bytes[0];
    b1 = win_bytes[1][5:0];
    b2 = win_bytes[2][5:0];
    b3 = win_bytes[3][5:0];
    bad_lead = (b0 <= 8'hBF) || (b0 == 8'hC0) || (b0 == 8'hC1) || (b0 > 8'hF4);
    cp   = REPL_CHAR;
    len  = 3'd1;
    repl = 1'b1;
    if (b0 <= 8'h7F) begin
      cp   = {13'd0, b0};
      repl = 1'b0;
    end else if (!bad_lead && b0[7:5] == 3'b110 && is_cont(1)) begin
      cp   = {10'd0, b0[4:0], b1};
      len  = 3'd2;
      repl = 1'b0;
    end else if (!bad_lead && b0[7:4] == 4'b1110 && is_cont(1) && is_cont(2)) begin
      cp   = {5'd0, b0[3:0], b1, b2};
      len  = 3'd3;
      repl = 1'b0;
    end else if (!bad_lead && b0[7:3] == 5'b11110 && is_cont(1) && is_cont(2) &&
                 is_cont(3)) begin
      cp   = {b0[2:0], b1, b2, b3};
      len  = 3'd4;
      repl = 1'b0;
    end
  endfunction

  // Append one byte and queue the results it releases
  task automatic decode_byte(input logic [7:0] b, input logic eos);
    logic [20:0] cp;
    logic [2:0]  len;
    logic        repl;
    res_t        r;
    int          n;
    int          i;
    n = 0;
    if (win_fill < WIN_DEPTH) begin
      win_bytes[win_fill[1:0]] = b;
      win_fill = win_fill + 3'd1;
    end
    while (win_fill > 0 && n < WIN_DEPTH && (win_fill >= WIN_DEPTH || eos)) begin
      decode_front(cp, len, repl);
      r.code_point   = cp;
      r.seq_length   = len;
      r.replaced     = repl;
      r.start_offset = win_offset;
      r.last_of_run  = 1'b0;
      cp_expected.push_back(r);
      // Shift out the consumed bytes and clear the vacated slots
      for (i = 0; i < WIN_DEPTH; i++) begin
        if (i + int'(len) < WIN_DEPTH) begin
          win_bytes[i] = win_bytes[i + int'(len)];
        end else begin
          win_bytes[i] = 8'h00;
        end
      end
      win_fill   = (win_fill > len) ? win_fill - len : 3'd0;
      win_offset = win_offset + OFS_BITS'(len);
      n++;
      if (!eos) break;
    end
    // Mark the final result of this byte
    if (n > 0) begin
      r = cp_expected.pop_back();
      r.last_of_run = 1'b1;
      cp_expected.push_back(r);
    end
  endtask

  // Compare one popped beat with the oldest prediction
  task automatic check_beat();
    res_t want;
    if (cp_expected.size() == 0) begin
      report($sformatf("unexpected result cp=%h", code_point));
    end else begin
      want = cp_expected.pop_front();
      if (code_point !== want.code_point)
        report($sformatf("code_point %h, want %h", code_point, want.code_point));
      if (seq_length !== want.seq_length)
        report($sformatf("seq_length %0d, want %0d", seq_length, want.seq_length));
      if (replaced !== want.replaced)
        report($sformatf("replaced %b, want %b", replaced, want.replaced));
      if (start_offset !== want.start_offset)
        report($sformatf("start_offset %0d, want %0d", start_offset, want.start_offset));
      if (last_of_run !== want.last_of_run)
        report($sformatf("last_of_run %b, want %b", last_of_run, want.last_of_run));
    end
  endtask

  // Check popped beats, then predict from pushed beats
  always @(posedge clk) begin
    if (rst) begin
      cp_expected.delete();
      for (int i = 0; i < WIN_DEPTH; i++) win_bytes[i] = 8'h00;
      win_fill   = 3'd0;
      win_offset = '0;
    end else begin
      if (pop && !empty) check_beat();
      if (push && !full) decode_byte(data_byte, end_of_stream);
    end
    pending = cp_expected.size();
  end

endmodule

@@ dv/utf8_stream_decoder_top_tb.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top_tb
// Drives byte beats into the UTF-8 stream decoder: a directed stream of
// boundary bytes first, then random streams of mostly well-formed sequences
// mixed with broken ones and noise, under three idling profiles and one long
// receiver hold-off. The checker beside the block does all comparisons.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_decoder_top_tb;

  localparam int RESET_CYCLES   = 10;
  localparam int PHASE_BYTES    = 62;
  localparam int HOLD_CYCLES    = 80;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        end_of_stream;
  logic        empty;
  logic        pop;
  logic [20:0] code_point;
  logic [2:0]  seq_length;
  logic        replaced;
  logic [31:0] start_offset;
  logic        last_of_run;

  int          chk_fails;
  int          chk_pending;

  // Idle percentages of both sides, and the one-shot hold-off request
  int          send_idle;
  int          recv_idle;
  logic        hold_go;
  logic        hold_taken;
  int          hold_left;
  int          stall_cycles;

  // Directed beats: bit 8 is end_of_stream
  logic [8:0]  directed [$] = '{
    9'h000, 9'h07F,                     // ASCII extremes
    9'h0C2, 9'h0A9,                     // two-byte form
    9'h080, 9'h0C0, 9'h0F5, 9'h0FF,     // bad leads
    9'h0E2, 9'h082, 9'h0AC,             // three-byte form
    9'h0F0, 9'h09F, 9'h098, 9'h080,     // four-byte form
    9'h0F4, 9'h0BF, 9'h0BF, 9'h0BF,     // F4 beyond the usual ceiling
    9'h0ED, 9'h0A0, 9'h080,             // surrogate
    9'h0E2, 9'h182,                     // truncated sequence at flush
    9'h141                              // flush of a lone byte
  };

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  utf8_stream_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .empty         (empty),
    .pop           (pop),
    .code_point    (code_point),
    .seq_length    (seq_length),
    .replaced      (replaced),
    .start_offset  (start_offset),
    .last_of_run   (last_of_run)
  );

  utf8_stream_decoder_chk chk (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .empty         (empty),
    .pop           (pop),
    .code_point    (code_point),
    .seq_length    (seq_length),
    .replaced      (replaced),
    .start_offset  (start_offset),
    .last_of_run   (last_of_run),
    .fail_count    (chk_fails),
    .pending       (chk_pending)
  );

  // Offer one byte beat, after a random gap, and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Send one random token: mostly well-formed, some broken, some noise
  task automatic send_token(output int nbytes);
    logic [7:0] seq [4];
    int         kind;
    int         i;
    kind = $urandom_range(99);
    nbytes = 1;
    if (kind < 30) begin
      seq[0] = 8'($urandom_range(8'h7F));
    end else if (kind < 50) begin
      seq[0] = 8'hC0 | 8'($urandom_range(2, 31));
      nbytes = 2;
    end else if (kind < 65) begin
      seq[0] = 8'hE0 | 8'($urandom_range(15));
      nbytes = 3;
    end else if (kind < 80) begin
      seq[0] = 8'hF0 | 8'($urandom_range(4));
      nbytes = 4;
    end else if (kind < 90) begin
      // Multi-byte lead cut short
      seq[0] = 8'($urandom_range(8'hE0, 8'hF7));
      nbytes = $urandom_range(1, 2);
    end else begin
      seq[0] = 8'($urandom_range(255));
    end
    for (i = 1; i < nbytes; i++) seq[i] = 8'h80 | 8'($urandom_range(63));
    for (i = 0; i < nbytes; i++) send_byte(seq[i], $urandom_range(19) == 0);
  endtask

  task automatic send_phase(input int want_bytes);
    int sent;
    int n;
    sent = 0;
    while (sent < want_bytes) begin
      send_token(n);
      sent += n;
    end
  endtask

  // Receiver: random pops, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop        <= 1'b0;
      hold_taken = 1'b0;
      hold_left  = 0;
    end else if (hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
      pop        <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("utf8_stream_decoder_top_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    push          = 1'b0;
    data_byte     = 8'h00;
    end_of_stream = 1'b0;
    hold_go       = 1'b0;
    send_idle     = 19;
    recv_idle     = 80;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed stream, then random under a slow receiver
    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    send_phase(PHASE_BYTES);

    // Slow sender, eager receiver
    send_idle = 80;
    recv_idle = 19;
    send_phase(PHASE_BYTES);

    // No idling; the receiver holds off once so the block backs up
    send_idle = 0;
    recv_idle = 0;
    hold_go   = 1'b1;
    send_phase(PHASE_BYTES);
    push <= 1'b0;

    // Drain, then let stray beats show up
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (chk_fails == 0 && chk_pending == 0) begin
      $display("utf8_stream_decoder_top_tb passed");
    end else begin
      $display("utf8_stream_decoder_top_tb failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/u8sd_pkg.sv
design/u8sd_front.sv
design/u8sd_back.sv
design/utf8_stream_decoder_top.sv
dv/utf8_stream_decoder_chk.sv
dv/utf8_stream_decoder_top_tb.sv
